// File: design/lzsw_pkg.sv
// Shared constants, state type and control structs of the LZSS window decoder.
`default_nettype none

package lzsw_pkg;

	// The window depth must be a power of two between 32 and 4096.
	localparam int WIN_DEPTH = 1024;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int FILL_W    = WIN_AW + 1;
	localparam int MIN_MATCH = 3;
	localparam int MAX_MATCH = 18;
	localparam int LEFT_W    = 5;
	localparam int FLAG_BITS = 8;
	localparam int COUNT_W   = 4;

	localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(WIN_DEPTH - MAX_MATCH);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_COPY
	} state_t;

	typedef struct packed {
		logic accept;
		logic copy_step;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic start_copy;
		logic last_copy;
	} status_t;

endpackage

`default_nettype wire

// File: design/lzsw_ctrl.sv
// Controller state machine that sequences input words and window copies.
`default_nettype none

module lzsw_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire lzsw_pkg::status_t status,
	output lzsw_pkg::cmd_t       cmd,
	output logic                 in_stall
);

	lzsw_pkg::state_t state_q;
	lzsw_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			lzsw_pkg::ST_IDLE: begin
				if (cmd.accept && status.start_copy) begin
					state_next = lzsw_pkg::ST_COPY;
				end
			end
			lzsw_pkg::ST_COPY: begin
				if (cmd.copy_step && status.last_copy) begin
					state_next = lzsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lzsw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall       = 1'b1;
		cmd.accept     = 1'b0;
		cmd.copy_step  = 1'b0;
		case (state_q)
			lzsw_pkg::ST_IDLE: begin
				in_stall   = !status.out_free;
				cmd.accept = in_valid && status.out_free;
			end
			lzsw_pkg::ST_COPY: begin
				cmd.copy_step = status.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/lzsw_dpath.sv
// Datapath with flag decoding, the ring window memory, copy counters and output register.
`default_nettype none

module lzsw_dpath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       in_byte,
	input  wire logic             stream_start,
	input  wire logic             out_stall,
	input  wire lzsw_pkg::cmd_t   cmd,
	output lzsw_pkg::status_t     status,
	output logic                  out_valid,
	output logic [7:0]            out_byte,
	output logic                  run_last
);

	localparam int AW = lzsw_pkg::WIN_AW;

	logic [7:0]                      window_mem [lzsw_pkg::WIN_DEPTH];
	logic [7:0]                      mem_rd_q;
	logic                            hit_q;
	logic [7:0]                      fwd_q;
	logic                            written_q;

	logic [AW-1:0]                   write_pos_q;
	logic [lzsw_pkg::FILL_W-1:0]     fill_q;
	logic [lzsw_pkg::FLAG_BITS-1:0]  flag_bits_q;
	logic [lzsw_pkg::COUNT_W-1:0]    flag_count_q;
	logic                            phase_q;
	logic [7:0]                      token_low_q;
	logic [AW-1:0]                   copy_pos_q;
	logic [lzsw_pkg::LEFT_W-1:0]     copy_left_q;
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            run_last_q;

	logic [11:0]                     offset;
	logic [lzsw_pkg::LEFT_W-1:0]     match_len;
	logic                            literal;
	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	logic [AW-1:0]                   rd_rel;
	logic                            rd_written;
	logic [7:0]                      rd_data;
	logic                            wr_en;
	logic [7:0]                      wr_data;
	logic                            last_copy;

	assign offset     = {in_byte[7:4], token_low_q};
	assign match_len  = lzsw_pkg::LEFT_W'(in_byte[3:0]) + lzsw_pkg::LEFT_W'(lzsw_pkg::MIN_MATCH);
	assign last_copy  = (copy_left_q == lzsw_pkg::LEFT_W'(1));
	assign literal    = cmd.accept && !stream_start && !phase_q
		&& (flag_count_q != '0) && flag_bits_q[0];

	assign rd_addr    = cmd.accept ? offset[AW-1:0] : copy_pos_q;
	assign rd_en      = (cmd.accept && phase_q && !stream_start)
		|| (cmd.copy_step && !last_copy);
	assign rd_rel     = rd_addr - lzsw_pkg::START_POS;
	assign rd_written = ({1'b0, rd_rel} < fill_q);
	assign rd_data    = hit_q ? fwd_q : (written_q ? mem_rd_q : 8'h00);

	assign wr_en      = literal || cmd.copy_step;
	assign wr_data    = cmd.copy_step ? rd_data : in_byte;

	// Entries outside the written span since stream start read as zero.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			window_mem[write_pos_q] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= window_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit_q     <= wr_en && (rd_addr == write_pos_q);
			fwd_q     <= wr_data;
			written_q <= rd_written;
		end
		if (cmd.accept && !stream_start && !phase_q && (flag_count_q != '0)
			&& !flag_bits_q[0]) begin
			token_low_q <= in_byte;
		end
		if (wr_en) begin
			out_byte_q <= wr_data;
			run_last_q <= literal || last_copy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q  <= lzsw_pkg::START_POS;
			fill_q       <= '0;
			flag_bits_q  <= '0;
			flag_count_q <= '0;
			phase_q      <= 1'b0;
			copy_pos_q   <= '0;
			copy_left_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.accept && stream_start) begin
				write_pos_q  <= lzsw_pkg::START_POS;
				fill_q       <= '0;
				flag_bits_q  <= in_byte;
				flag_count_q <= lzsw_pkg::COUNT_W'(lzsw_pkg::FLAG_BITS);
				phase_q      <= 1'b0;
				copy_left_q  <= '0;
			end else begin
				if (wr_en) begin
					write_pos_q <= write_pos_q + AW'(1);
					if (fill_q != lzsw_pkg::FILL_W'(lzsw_pkg::WIN_DEPTH)) begin
						fill_q <= fill_q + lzsw_pkg::FILL_W'(1);
					end
				end
				if (cmd.accept) begin
					if (phase_q) begin
						phase_q     <= 1'b0;
						copy_pos_q  <= offset[AW-1:0] + AW'(1);
						copy_left_q <= match_len;
					end else if (flag_count_q == '0) begin
						flag_bits_q  <= in_byte;
						flag_count_q <= lzsw_pkg::COUNT_W'(lzsw_pkg::FLAG_BITS);
					end else begin
						flag_bits_q  <= {1'b0, flag_bits_q[lzsw_pkg::FLAG_BITS-1:1]};
						flag_count_q <= flag_count_q - lzsw_pkg::COUNT_W'(1);
						phase_q      <= !flag_bits_q[0];
					end
				end
				if (cmd.copy_step) begin
					copy_left_q <= copy_left_q - lzsw_pkg::LEFT_W'(1);
					if (!last_copy) begin
						copy_pos_q <= copy_pos_q + AW'(1);
					end
				end
			end
		end
	end

	assign status.out_free   = !out_valid_q || !out_stall;
	assign status.start_copy = phase_q && !stream_start;
	assign status.last_copy  = last_copy;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

// File: design/lzss_window_decoder.sv
// Top level of the LZSS window decoder: controller and datapath.
//
//   channel  direction  handshake             fields
//   in       sink       in_valid / in_stall   in_byte, stream_start
//   out      source     out_valid / out_stall out_byte, run_last
//
// A flag word, the first token word and a literal are each taken as one input word;
// a token's second word starts a copy of 3 to 18 bytes, written out one after another,
// bound by the single read port and registered read of the window memory.
// Reset needs no clearing pass: a fill count makes unwritten window entries read as zero.
// A stall on the output holds the copy in place; no input word is taken during a copy.
`default_nettype none

module lzss_window_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       stream_start,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	lzsw_pkg::cmd_t    cmd;
	lzsw_pkg::status_t status;

	lzsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	lzsw_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.stream_start (stream_start),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

endmodule

`default_nettype wire

// File: design/lzsw_checker.sv
// Port-level checker for the LZSS window decoder and its bind statement.
`default_nettype none

module lzsw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       stream_start,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       run_last
);

	// A stalled input word holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(stream_start))
		else $error("input word changed while stalled");

	// A stalled output word holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output word changed while stalled");

	// A stream start word only loads flags, so no output word follows it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && stream_start |=> !out_valid)
		else $error("output word after stream start");

	// While a copy is unfinished no input word is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> in_stall)
		else $error("input taken in the middle of a copy");

	// A blocked output register blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output is blocked");

endmodule

bind lzss_window_decoder lzsw_checker u_lzsw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.in_byte      (in_byte),
	.stream_start (stream_start),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.run_last     (run_last)
);

`default_nettype wire
